// ===== src/line_follow_mode_supervisor_macros.svh =====
// Assertion macros used by the line-follow mode supervisor checker
`ifndef LINE_FOLLOW_MODE_SUPERVISOR_MACROS_SVH
`define LINE_FOLLOW_MODE_SUPERVISOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LFMS_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LFMS_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lfms_pkg.sv =====
// Package: shared types and constants of the line-follow mode supervisor
`timescale 1ns / 1ps

package lfms_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_DEGR  = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_FAULT = 3'd4
    } mode_t;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_RESET = 2'd3;

    localparam logic [2:0] CFG_FAULT_FRAMES     = 3'd0;
    localparam logic [2:0] CFG_LOST_STOP_FRAMES = 3'd1;
    localparam logic [2:0] CFG_RECOVERY_FRAMES  = 3'd2;
    localparam logic [2:0] CFG_IDLE_SPEED       = 3'd3;
    localparam logic [2:0] CFG_LINE_SPEED       = 3'd4;
    localparam logic [2:0] CFG_DEGRADED_SPEED   = 3'd5;
    localparam logic [2:0] CFG_ERROR_GAIN       = 3'd6;

    // Q1.15 speed factor: unity and the 0.4 floor
    localparam logic [15:0] FACTOR_ONE   = 16'd32768;
    localparam logic [15:0] FACTOR_FLOOR = 16'd13107;
    localparam logic [25:0] RED_LIMIT    = 26'(FACTOR_ONE - FACTOR_FLOOR);

    localparam logic [7:0] CNT_MAX = 8'hFF;

    localparam int DIV_STEPS  = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0]  fault_frames;
        logic [7:0]  lost_stop_frames;
        logic [7:0]  recovery_frames;
        logic [15:0] idle_speed;
        logic [15:0] line_speed;
        logic [15:0] degraded_speed;
        logic [15:0] error_gain;
    } cfg_t;

    // One classified request handed from the front to the back
    typedef struct packed {
        mode_t              mode;
        logic [16:0]        mag;
        logic [7:0]         lost;
        logic signed [15:0] held;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RED,
        BK_FAC,
        BK_SCALE,
        BK_DMUL,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

// ===== src/lfms_front.sv =====
// Front end: mode state machine, failure and lost-line counters, offset latch
`timescale 1ns / 1ps

module lfms_front import lfms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic               localization_ok,
    input  logic               line_seen,
    input  logic signed [15:0] lateral_offset,
    output logic               job_valid,
    input  logic               job_ready,
    output job_t               job
);

    mode_t              mode_reg, mode_next;
    logic [7:0]         lost_reg, lost_next;
    logic [7:0]         fail_reg, fail_next;
    logic signed [15:0] latch_reg, latch_next;
    logic               accept;
    logic [7:0]         lost_inc;

    assign accept = in_valid && job_ready;

    always_comb begin
        lost_inc  = (lost_reg == CNT_MAX) ? lost_reg : lost_reg + 8'd1;
        fail_next = (!localization_ok && !line_seen)
                  ? ((fail_reg == CNT_MAX) ? fail_reg : fail_reg + 8'd1) : 8'd0;
        latch_next = (mode_reg == MODE_RUN) ? lateral_offset : latch_reg;
        mode_next  = mode_reg;
        lost_next  = lost_reg;
        priority if (command == CMD_STOP) begin
            mode_next = MODE_STOP;
        end else if ((mode_reg == MODE_RUN || mode_reg == MODE_DEGR)
                     && fail_next >= cfg.fault_frames) begin
            mode_next = MODE_FAULT;
        end else if (command == CMD_RESET && localization_ok && line_seen) begin
            mode_next = MODE_IDLE;
        end else if (!line_seen) begin
            if (mode_reg == MODE_RUN) begin
                lost_next = 8'd1;
                mode_next = MODE_DEGR;
            end else if (mode_reg == MODE_DEGR) begin
                lost_next = lost_inc;
                if (lost_inc > cfg.lost_stop_frames) begin
                    mode_next = MODE_STOP;
                end
            end
        end else begin
            if (mode_reg == MODE_DEGR && lost_reg <= cfg.recovery_frames) begin
                mode_next = MODE_RUN;
                lost_next = 8'd0;
            end else if (mode_reg == MODE_IDLE && command == CMD_START && localization_ok) begin
                mode_next = MODE_RUN;
            end
        end
    end

    // Classified request for the back end
    always_comb begin
        in_ready  = job_ready;
        job_valid = in_valid;
        job.mode  = mode_next;
        job.lost  = lost_next;
        job.held  = latch_next;
        job.mag   = lateral_offset[15] ? (17'(~lateral_offset) + 17'd1)
                                       : {1'b0, lateral_offset};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            lost_reg  <= 8'd0;
            fail_reg  <= 8'd0;
            latch_reg <= 16'sd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            lost_reg  <= lost_next;
            fail_reg  <= fail_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== src/lfms_queue.sv =====
// Short request queue between the front and the back end
`timescale 1ns / 1ps

module lfms_queue import lfms_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/lfms_back.sv =====
// Back end: speed limit sequencer with shared multiplier and serial divider
`timescale 1ns / 1ps

module lfms_back import lfms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_mode,
    output logic [15:0]        m_speed_limit,
    output logic signed [15:0] m_held_offset
);

    back_state_t        state_reg, state_next;
    job_t               work_reg, work_next;
    logic [32:0]        prod_reg, prod_next;
    logic [15:0]        factor_reg, factor_next;
    logic [15:0]        speed_reg, speed_next;
    logic [23:0]        quo_reg, quo_next;
    logic [7:0]         rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               ov_reg, ov_next;
    logic [2:0]         om_reg, om_next;
    logic [15:0]        os_reg, os_next;
    logic signed [15:0] oh_reg, oh_next;

    logic        take, load_out, out_free, degr_zero;
    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] mul_p;
    logic [25:0] red;
    logic [8:0]  rem_sh;
    logic        ge;

    assign out_free  = !ov_reg || m_ready;
    assign degr_zero = (cfg.lost_stop_frames == 8'd0) || (job.lost >= cfg.lost_stop_frames);
    assign mul_p     = 33'(mul_a) * 33'(mul_b);
    assign red       = prod_reg[32:7];
    assign rem_sh    = {rem_reg, quo_reg[23]};
    assign ge        = rem_sh >= {1'b0, cfg.lost_stop_frames};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    unique case (job.mode)
                        MODE_RUN:  state_next = BK_RED;
                        MODE_DEGR: state_next = degr_zero ? BK_OUT : BK_DMUL;
                        default:   state_next = BK_OUT;
                    endcase
                end
            end
            BK_RED:   state_next = BK_FAC;
            BK_FAC:   state_next = BK_SCALE;
            BK_SCALE: state_next = BK_OUT;
            BK_DMUL:  state_next = BK_DIV;
            BK_DIV:   state_next = (cnt_reg == 5'd1) ? BK_OUT : BK_DIV;
            BK_OUT:   state_next = out_free ? BK_IDLE : BK_OUT;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Control outputs and multiplier operands
    always_comb begin
        take     = 1'b0;
        load_out = 1'b0;
        mul_a    = cfg.error_gain;
        mul_b    = work_reg.mag;
        unique case (state_reg)
            BK_IDLE:  take = job_valid;
            BK_SCALE: begin
                mul_a = cfg.line_speed;
                mul_b = {1'b0, factor_reg};
            end
            BK_DMUL:  begin
                mul_a = cfg.degraded_speed;
                mul_b = {9'd0, cfg.lost_stop_frames - work_reg.lost};
            end
            BK_OUT:   load_out = out_free;
            default:  ;
        endcase
    end
    assign job_ready = take;

    // Datapath
    always_comb begin
        work_next   = work_reg;
        prod_next   = prod_reg;
        factor_next = factor_reg;
        speed_next  = speed_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            BK_IDLE: begin
                work_next = job;
                unique case (job.mode)
                    MODE_IDLE: speed_next = cfg.idle_speed;
                    default:   speed_next = 16'd0;
                endcase
            end
            BK_RED:   prod_next = mul_p;
            BK_FAC:   factor_next = (red >= RED_LIMIT) ? FACTOR_FLOOR : FACTOR_ONE - red[15:0];
            BK_SCALE: speed_next = mul_p[30:15];
            BK_DMUL: begin
                quo_next = mul_p[23:0];
                rem_next = 8'd0;
                cnt_next = 5'(DIV_STEPS);
            end
            BK_DIV: begin
                rem_next = ge ? 8'(rem_sh - {1'b0, cfg.lost_stop_frames}) : rem_sh[7:0];
                quo_next = {quo_reg[22:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    speed_next = quo_next[15:0];
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_comb begin
        ov_next = ov_reg;
        om_next = om_reg;
        os_next = os_reg;
        oh_next = oh_reg;
        if (load_out) begin
            ov_next = 1'b1;
            om_next = work_reg.mode;
            os_next = speed_reg;
            oh_next = work_reg.held;
        end else if (m_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            work_reg <= work_next;
        end
        prod_reg   <= prod_next;
        factor_reg <= factor_next;
        speed_reg  <= speed_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        om_reg     <= om_next;
        os_reg     <= os_next;
        oh_reg     <= oh_next;
    end

    assign m_valid       = ov_reg;
    assign m_mode        = om_reg;
    assign m_speed_limit = os_reg;
    assign m_held_offset = oh_reg;

endmodule

// ===== src/line_follow_mode_supervisor.sv =====
// Top level: line-follow mode supervisor with configuration registers
`timescale 1ns / 1ps

// Line-follow mode supervisor. Each request is one sensor frame (command,
// localisation and line flags, signed lateral error in 1/1024 units); each
// frame yields exactly one result with the new mode (0 idle, 1 running,
// 2 degraded, 3 stopped, 4 fault), a speed limit in mm/s and the lateral
// error last latched while running. The front end updates the mode and the
// counters in the cycle a request is taken and can take one request per
// cycle while its two-entry queue has room. The back end then works out the
// speed limit: idle, stopped and fault frames go from take to output load;
// running frames pass take, gain multiply, factor clamp, line-speed multiply
// and output load; degraded frames pass a degraded-speed multiply and the
// one-bit-per-cycle 24-step divider that scales the degraded speed by the
// remaining lost-frame budget, or get a zero limit once it is spent. As it
// takes a new frame only after loading the last result, the back end sets
// the sustained throughput. A result waits in its own output register, so
// the back end stalls only while the next result waits on an unread one.
// Write configuration only while no request is in flight.

module line_follow_mode_supervisor import lfms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    // frame requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic               s_localization_ok,
    input  logic               s_line_seen,
    input  logic signed [15:0] s_lateral_offset,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_mode,
    output logic [15:0]        m_speed_limit,
    output logic signed [15:0] m_held_offset
);

    cfg_t cfg_reg, cfg_next;
    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    // Register file: unknown indexes drop the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FAULT_FRAMES:     cfg_next.fault_frames     = cfg_wdata[7:0];
                CFG_LOST_STOP_FRAMES: cfg_next.lost_stop_frames = cfg_wdata[7:0];
                CFG_RECOVERY_FRAMES:  cfg_next.recovery_frames  = cfg_wdata[7:0];
                CFG_IDLE_SPEED:       cfg_next.idle_speed       = cfg_wdata;
                CFG_LINE_SPEED:       cfg_next.line_speed       = cfg_wdata;
                CFG_DEGRADED_SPEED:   cfg_next.degraded_speed   = cfg_wdata;
                CFG_ERROR_GAIN:       cfg_next.error_gain       = cfg_wdata;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fault_frames     <= 8'd5;
            cfg_reg.lost_stop_frames <= 8'd20;
            cfg_reg.recovery_frames  <= 8'd10;
            cfg_reg.idle_speed       <= 16'd0;
            cfg_reg.line_speed       <= 16'd500;
            cfg_reg.degraded_speed   <= 16'd200;
            cfg_reg.error_gain       <= 16'd4096;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify the frame and advance the mode
    lfms_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .command         (s_command),
        .localization_ok (s_localization_ok),
        .line_seen       (s_line_seen),
        .lateral_offset  (s_lateral_offset),
        .job_valid       (fq_valid),
        .job_ready       (fq_ready),
        .job             (fq_job)
    );

    // Hold classified requests while the back end is busy
    lfms_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    // Compute the speed limit and present the result
    lfms_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .job_valid     (qb_valid),
        .job_ready     (qb_ready),
        .job           (qb_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mode        (m_mode),
        .m_speed_limit (m_speed_limit),
        .m_held_offset (m_held_offset)
    );

endmodule

// ===== src/lfms_checker.sv =====
// Port-level checker for the line-follow mode supervisor, bound to the top level
`timescale 1ns / 1ps
`include "line_follow_mode_supervisor_macros.svh"

module lfms_checker import lfms_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_mode,
    input logic [15:0]        m_speed_limit,
    input logic signed [15:0] m_held_offset
);

    // A stopped or faulted vehicle always gets a zero limit
    `LFMS_ASSERT_IMP(a_halt_zero, aclk, !aresetn, m_valid && (m_mode == MODE_STOP || m_mode == MODE_FAULT), m_speed_limit == 16'd0, "speed limit not zero in stopped or fault mode")

    // A pending result holds until taken
    `LFMS_ASSERT_NXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_mode) && $stable(m_speed_limit) && $stable(m_held_offset), "pending result changed before it was taken")

    // Reset empties the pipeline and reopens the input
    `LFMS_ASSERT_NXT(a_reset_clear, aclk, 1'b0, !aresetn, !m_valid && s_ready, "block not empty after reset")

endmodule

bind line_follow_mode_supervisor lfms_checker u_lfms_checker (.*);
